>>> rtl/core/fisr_pkg.sv
// Shared types, constants and binary32 arithmetic for the fast inverse square root unit.
package fisr_pkg;

    localparam logic [31:0] SEED_MAGIC      = 32'h5f3759df;
    localparam logic [31:0] FP_HALF         = 32'h3f000000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;
    localparam logic [31:0] FP_QNAN         = 32'h7fc00000;
    localparam logic [31:0] MAG_MASK        = 32'h7fffffff;
    localparam logic [31:0] EXP_ONES        = 32'h7f800000;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_DOMAIN = 2'd1;
    localparam logic [1:0] ERR_ZERO   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        action;
        logic [31:0] operand;
        logic [1:0]  err;
        logic        is_zero;
    } fisr_item_t;

    typedef struct packed {
        logic        action;
        logic [31:0] operand;
        logic [1:0]  err;
        logic        is_zero;
        logic [31:0] seed;
    } fisr_ctx_t;

    function automatic logic fp_is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    endfunction

    // binary32 multiply, round to nearest even, subnormals kept
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               sign;
        logic [7:0]         ea;
        logic [7:0]         eb;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic [47:0]        p;
        logic [47:0]        pn;
        logic [5:0]         lz;
        logic               found;
        logic signed [10:0] e;
        logic [10:0]        sh;
        logic               lost;
        logic [7:0]         ef;
        logic               rnd;
        logic [30:0]        w;
        logic [31:0]        res;
        begin
            sign = a[31] ^ b[31];
            res  = 32'd0;
            if (fp_is_nan(a) || fp_is_nan(b))
            begin
                res = FP_QNAN;
            end
            else if (fp_is_inf(a) || fp_is_inf(b))
            begin
                if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0))
                    res = FP_QNAN;
                else
                    res = {sign, EXP_ONES[30:0]};
            end
            else if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0))
            begin
                res = {sign, 31'd0};
            end
            else
            begin
                ma = {a[30:23] != 8'd0, a[22:0]};
                mb = {b[30:23] != 8'd0, b[22:0]};
                ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
                eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
                p  = ma * mb;
                lz    = 6'd0;
                found = 1'b0;
                for (int i = 47; i >= 0; i--)
                begin
                    if (!found)
                    begin
                        if (p[i])
                            found = 1'b1;
                        else
                            lz = lz + 6'd1;
                    end
                end
                pn   = p << lz;
                e    = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126
                       - $signed({5'b00000, lz});
                lost = 1'b0;
                if (e >= 11'sd255)
                begin
                    res = {sign, EXP_ONES[30:0]};
                end
                else
                begin
                    if (e < 11'sd1)
                    begin
                        sh = 11'(11'sd1 - e);
                        if (sh >= 11'd48)
                        begin
                            lost = |pn;
                            pn   = 48'd0;
                        end
                        else
                        begin
                            lost = |(pn & ((48'd1 << sh) - 48'd1));
                            pn   = pn >> sh;
                        end
                        ef = 8'd0;
                    end
                    else
                    begin
                        ef = e[7:0];
                    end
                    rnd = pn[23] & ((|pn[22:0]) | lost | pn[24]);
                    w   = {ef, pn[46:24]} + {30'd0, rnd};
                    res = {sign, w};
                end
            end
            return res;
        end
    endfunction

    // binary32 add, round to nearest even, subnormals kept
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]        x;
        logic [31:0]        y;
        logic [7:0]         ex;
        logic [7:0]         ey;
        logic [7:0]         d;
        logic [26:0]        b0;
        logic [27:0]        av;
        logic [27:0]        bv;
        logic               lost;
        logic [27:0]        r;
        logic [4:0]         lz;
        logic [4:0]         lzl;
        logic               found;
        logic signed [10:0] e;
        logic [7:0]         ef;
        logic               rnd;
        logic [30:0]        w;
        logic [31:0]        res;
        begin
            res = 32'd0;
            if (fp_is_nan(a) || fp_is_nan(b))
            begin
                res = FP_QNAN;
            end
            else if (fp_is_inf(a) && fp_is_inf(b))
            begin
                res = (a[31] != b[31]) ? FP_QNAN : a;
            end
            else if (fp_is_inf(a))
            begin
                res = a;
            end
            else if (fp_is_inf(b))
            begin
                res = b;
            end
            else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            begin
                res = {a[31] & b[31], 31'd0};
            end
            else if (a[30:0] == 31'd0)
            begin
                res = b;
            end
            else if (b[30:0] == 31'd0)
            begin
                res = a;
            end
            else
            begin
                if (b[30:0] > a[30:0])
                begin
                    x = b;
                    y = a;
                end
                else
                begin
                    x = a;
                    y = b;
                end
                ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
                ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
                d  = ex - ey;
                av = {1'b0, x[30:23] != 8'd0, x[22:0], 3'b000};
                b0 = {y[30:23] != 8'd0, y[22:0], 3'b000};
                if (d >= 8'd27)
                begin
                    lost = |b0;
                    bv   = 28'd0;
                end
                else
                begin
                    lost = |(b0 & ((27'd1 << d) - 27'd1));
                    bv   = {1'b0, b0 >> d};
                end
                bv[0] = bv[0] | lost;
                r = (x[31] ^ y[31]) ? (av - bv) : (av + bv);
                e = $signed({3'b000, ex});
                if (r == 28'd0)
                begin
                    res = 32'd0;
                end
                else
                begin
                    if (r[27])
                    begin
                        r = {1'b0, r[27:2], r[1] | r[0]};
                        e = e + 11'sd1;
                    end
                    else
                    begin
                        lz    = 5'd0;
                        found = 1'b0;
                        for (int i = 26; i >= 0; i--)
                        begin
                            if (!found)
                            begin
                                if (r[i])
                                    found = 1'b1;
                                else
                                    lz = lz + 5'd1;
                            end
                        end
                        lzl = ({3'b000, lz} > (ex - 8'd1)) ? 5'(ex - 8'd1) : lz;
                        r   = r << lzl;
                        e   = e - $signed({6'd0, lzl});
                    end
                    if (e >= 11'sd255)
                    begin
                        res = {x[31], EXP_ONES[30:0]};
                    end
                    else
                    begin
                        ef  = r[26] ? e[7:0] : 8'd0;
                        rnd = r[2] & (r[1] | r[0] | r[3]);
                        w   = {ef, r[25:3]} + {30'd0, rnd};
                        res = {x[31], w};
                    end
                end
            end
            return res;
        end
    endfunction

endpackage

>>> rtl/core/fisr_front.sv
// Front end: takes input items, classifies them and holds one for the queue.
module fisr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic [31:0]         operand_bits,
    output logic                item_valid,
    input  logic                item_ready,
    output fisr_pkg::fisr_item_t item
);
    import fisr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    fisr_item_t item_reg;
    fisr_item_t item_next;
    logic [31:0] mag;

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;
    assign mag        = operand_bits & MAG_MASK;

    always_comb
    begin
        item_next.action  = action;
        item_next.operand = operand_bits;
        item_next.is_zero = (mag == 32'd0);
        if ((mag > EXP_ONES) || (operand_bits[31] && (mag != 32'd0)))
            item_next.err = ERR_DOMAIN;
        else if ((mag == 32'd0) && !action)
            item_next.err = ERR_ZERO;
        else
            item_next.err = ERR_OK;
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule

>>> rtl/core/fisr_queue.sv
// Short item queue between the front end and the arithmetic pipeline.
module fisr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  fisr_pkg::fisr_item_t push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output fisr_pkg::fisr_item_t pop_item
);
    import fisr_pkg::*;

    fisr_item_t           mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;
    logic                 push;
    logic                 pop;

    assign push_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> rtl/core/fisr_back.sv
// Back end: seed, Newton step and optional square root multiply, one operation a stage.
module fisr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  fisr_pkg::fisr_item_t item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         result_bits,
    output logic [1:0]          error_code
);
    import fisr_pkg::*;

    logic        en;
    logic [5:0]  valid_reg;
    logic [5:0]  valid_next;
    fisr_ctx_t   ctx_reg [5];
    fisr_ctx_t   ctx_in;
    logic [31:0] half_x_reg;
    logic [31:0] t1_reg;
    logic [31:0] t2_reg;
    logic [31:0] t3_reg;
    logic [31:0] y1_reg;
    logic [31:0] result_reg;
    logic [31:0] result_next;
    logic [1:0]  err_reg;

    assign en          = !valid_reg[5] || out_ready;
    assign item_ready  = en;
    assign out_valid   = valid_reg[5];
    assign result_bits = result_reg;
    assign error_code  = err_reg;

    always_comb
    begin
        ctx_in.action  = item.action;
        ctx_in.operand = item.operand;
        ctx_in.err     = item.err;
        ctx_in.is_zero = item.is_zero;
        ctx_in.seed    = SEED_MAGIC - {1'b0, item.operand[31:1]};
        valid_next     = {valid_reg[4:0], item_valid};
        if ((ctx_reg[4].err != ERR_OK) || ctx_reg[4].is_zero)
            result_next = 32'd0;
        else if (ctx_reg[4].action)
            result_next = fp_mul(ctx_reg[4].operand, y1_reg);
        else
            result_next = y1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= ctx_in;
            for (int i = 1; i < 5; i++)
                ctx_reg[i] <= ctx_reg[i-1];
            half_x_reg <= fp_mul(item.operand, FP_HALF);
            t1_reg     <= fp_mul(half_x_reg, ctx_reg[0].seed);
            t2_reg     <= fp_mul(t1_reg, ctx_reg[1].seed);
            t3_reg     <= fp_add(FP_THREE_HALVES, {~t2_reg[31], t2_reg[30:0]});
            y1_reg     <= fp_mul(ctx_reg[3].seed, t3_reg);
            result_reg <= result_next;
            err_reg    <= ctx_reg[4].err;
        end
    end

endmodule

>>> rtl/core/fast_inverse_sqrt_unit_top.sv
// Top level of the fast inverse square root unit.
//
// Input channel: in_valid/in_ready with action (0 = 1/sqrt(x), 1 = sqrt(x))
// and operand_bits, a binary32 pattern. Output channel: out_valid/out_ready
// with result_bits and error_code (0 ok, 1 negative or NaN, 2 zero for the
// inverse). result_bits is zero whenever error_code is not ok.
// One item in, one item out, in order.
// Path to out_valid with no stall: the front register loads at acceptance,
// then one queue slot and six back-end stages (halving, two multiplies,
// subtract, multiply, final multiply and select).
// Throughput: one item per cycle while out_ready stays high; each back-end
// stage holds one binary32 operation.
// Reset clears all valid flags and the queue; no result is pending after it.
// When the receiver stalls the back end holds, the 4-entry queue and front
// register keep filling, and in_ready falls once all are full.
module fast_inverse_sqrt_unit_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] operand_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_bits,
    output logic [1:0]  error_code
);
    import fisr_pkg::*;

    logic       f_valid;
    logic       f_ready;
    fisr_item_t f_item;
    logic       q_valid;
    logic       q_ready;
    fisr_item_t q_item;

    fisr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .operand_bits (operand_bits),
        .item_valid   (f_valid),
        .item_ready   (f_ready),
        .item         (f_item)
    );

    fisr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    fisr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (q_valid),
        .item_ready  (q_ready),
        .item        (q_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_bits (result_bits),
        .error_code  (error_code)
    );

endmodule

>>> rtl/core/fisr_checker.sv
// Port-level checks for the fast inverse square root unit, bound to the top level.
module fisr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_bits,
    input logic [1:0]  error_code
);
    import fisr_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(result_bits) && $stable(error_code))
        else $error("output item changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != ERR_OK) |-> (result_bits == 32'd0))
        else $error("nonzero result with error");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (error_code == ERR_OK) || (error_code == ERR_DOMAIN)
                      || (error_code == ERR_ZERO))
        else $error("undefined error code");

endmodule

bind fast_inverse_sqrt_unit_top fisr_checker u_fisr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_bits (result_bits),
    .error_code  (error_code)
);
